>>> rtl/cdeq_pkg.sv
`timescale 1ns / 1ps

package cdeq_pkg;

   // Number of words the queue can hold.
   localparam int DEPTH = 8;

   // Width of a cell position and of the occupancy counter.
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int OCC_W  = 4;

   // Requested action of one item.
   typedef enum logic [1:0] {
      ACT_PUSH_BACK  = 2'd0,
      ACT_PUSH_FRONT = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_BACK   = 2'd3
   } cdeq_act_type;

   // Outcome reported with every result.
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } cdeq_status_type;

   // One request item.
   typedef struct packed {
      cdeq_act_type              action;
      logic signed [WORD_W-1:0]  data_in;
   } cdeq_req_type;

   // One result item.
   typedef struct packed {
      logic signed [WORD_W-1:0]  data_out;
      cdeq_status_type           status;
      logic [OCC_W-1:0]          occupancy;
   } cdeq_rsp_type;

   // Command broadcast from the control logic to every cell.
   typedef struct packed {
      logic              shift_right;
      logic              shift_left;
      logic              write_back;
      logic [CNT_W-1:0]  count;
   } cdeq_ctrl_type;

endpackage

>>> rtl/cdeq_cell.sv
`timescale 1ns / 1ps

module cdeq_cell (
   input  logic                        clock,
   input  cdeq_pkg::cdeq_ctrl_type     ctrl,
   input  logic [cdeq_pkg::IDX_W-1:0]  cell_index,
   input  logic [cdeq_pkg::WORD_W-1:0] left_data,
   input  logic [cdeq_pkg::WORD_W-1:0] right_data,
   input  logic [cdeq_pkg::WORD_W-1:0] push_data,
   output logic [cdeq_pkg::WORD_W-1:0] cell_data,
   output logic [cdeq_pkg::WORD_W-1:0] back_data
);
   import cdeq_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic [CNT_W-1:0]  position;
   logic              is_back;

   // This cell's place in the row, widened to the counter width.
   assign position = CNT_W'(cell_index);

   // The cell holding the last stored word is the back of the queue.
   assign is_back = (ctrl.count != '0) && (position == ctrl.count - CNT_W'(1));

   // A push at the front moves every word one place toward the back, a pop at the
   // front moves every word one place toward the front, and a push at the back
   // writes the first free cell.
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end else if (ctrl.write_back && (position == ctrl.count)) begin
         data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;
   assign back_data = is_back ? data_ff : '0;

endmodule

>>> rtl/circular_double_ended_queue.sv
`timescale 1ns / 1ps

// Double-ended queue of DEPTH 32-bit words. An item is accepted on every clock
// edge where start is high; busy is always low, so one item can be issued every
// cycle. Its result appears on rsp_item in the next cycle, marked by rsp_strobe
// for exactly one cycle, and must be taken then. The words live in a row of
// cells kept in queue order with the front in the first cell; a push or pop at
// the front moves every cell one place together, and a pop at the back selects
// the last occupied cell, so each action ends with its result. A push
// to a full queue or a pop from an empty one changes nothing and reports its
// status with a zero data word. Occupancy is the word count after the action.
module circular_double_ended_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cdeq_pkg::cdeq_req_type req_item,
   output logic                   rsp_strobe,
   output cdeq_pkg::cdeq_rsp_type rsp_item
);
   import cdeq_pkg::*;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              strobe_ff;
   cdeq_rsp_type      rsp_ff;
   cdeq_rsp_type      rsp_in;
   cdeq_ctrl_type     ctrl;
   logic              accept;
   logic              full;
   logic              empty;
   logic [WORD_W-1:0] back_word;

   logic [WORD_W-1:0] cell_data [DEPTH];
   logic [WORD_W-1:0] back_data [DEPTH];
   logic [WORD_W-1:0] left_data [DEPTH];
   logic [WORD_W-1:0] right_data [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   // Command shared by all cells.
   always_comb begin
      ctrl.shift_right = accept && (req_item.action == ACT_PUSH_FRONT) && !full;
      ctrl.shift_left  = accept && (req_item.action == ACT_POP_FRONT) && !empty;
      ctrl.write_back  = accept && (req_item.action == ACT_PUSH_BACK) && !full;
      ctrl.count       = count_ff;
   end

   // The row of cells with links to both neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i] = $unsigned(req_item.data_in);
      end else begin : g_inner_left
         assign left_data[i] = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i] = cell_data[i];
      end else begin : g_inner_right
         assign right_data[i] = cell_data[i+1];
      end

      cdeq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .left_data  (left_data[i]),
         .right_data (right_data[i]),
         .push_data  ($unsigned(req_item.data_in)),
         .cell_data  (cell_data[i]),
         .back_data  (back_data[i])
      );
   end

   // Only the back cell drives a nonzero word, so an OR collects it.
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | back_data[i];
      end
   end

   // Result and new count for the accepted item.
   always_comb begin
      count_in         = count_ff;
      rsp_in.data_out  = '0;
      rsp_in.status    = STAT_DONE;
      unique case (req_item.action)
         ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (full) begin
               rsp_in.status = STAT_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.data_out = $signed(cell_data[0]);
               count_in        = count_ff - CNT_W'(1);
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.data_out = $signed(back_word);
               count_in        = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_in.status = STAT_DONE;
         end
      endcase
      rsp_in.occupancy = OCC_W'(count_in);
   end

   // Control state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // Every accepted item yields exactly one result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted item produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("result without an accepted item");

   // The word count never goes beyond the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond capacity");

   // A rejected action reports a zero word and leaves the count alone.
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status != STAT_DONE) |->
         (rsp_item.data_out == '0) && (count_ff == $past(count_ff)))
      else $error("rejected action changed state or returned data");

   // A successful push raises the count by one.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && !full &&
         ((req_item.action == ACT_PUSH_BACK) || (req_item.action == ACT_PUSH_FRONT)) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not add one word");

endmodule
